// ===== design/srtt_pkg.sv =====
// Shared types, constants and helper functions of the signed radix to text unit.
package srtt_pkg;

  localparam int unsigned MaxRadixDef   = 16;
  localparam int unsigned ValueWidthDef = 32;
  localparam int unsigned SymbolCount   = 16;
  localparam int unsigned RadixWidth    = 5;
  localparam int unsigned SymWordWidth  = 64;
  localparam int unsigned CfgIdxWidth   = 2;
  localparam int unsigned DigitWidth    = 4;

  localparam logic [RadixWidth-1:0] MinRadix = 5'd2;

  localparam logic [7:0] CharPlus  = 8'h2B;
  localparam logic [7:0] CharMinus = 8'h2D;
  localparam logic [7:0] CharNul   = 8'h00;

  // configuration register indexes
  localparam logic [CfgIdxWidth-1:0] RegRadix   = 2'd0;
  localparam logic [CfgIdxWidth-1:0] RegSymLow  = 2'd1;
  localparam logic [CfgIdxWidth-1:0] RegSymHigh = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIVIDE,
    ST_READ,
    ST_EMIT
  } seq_state_e;

  typedef struct packed {
    logic done;
    logic ok;
  } chk_stat_t;

  typedef struct packed {
    logic                  done;
    logic [DigitWidth-1:0] remainder;
  } div_stat_t;

  // symbol byte for digit idx; 0..7 from the low word, 8..15 from the high word
  function automatic logic [7:0] symbol_at(input logic [SymWordWidth-1:0] lo,
                                           input logic [SymWordWidth-1:0] hi,
                                           input logic [DigitWidth-1:0]   idx);
    logic [SymWordWidth-1:0] word;
    word = idx[3] ? hi : lo;
    return word[idx[2:0]*8 +: 8];
  endfunction

endpackage

// ===== design/signed_radix_to_text_unit.sv =====
// Top level of the signed radix to text unit: registers, sequencer, digit memory.
//
// Usage:
//   Configuration: write radix (index 0), symbols_low (1) and symbols_high (2)
//   through cfg_we_i/cfg_index_i/cfg_data_i while the unit is idle. Writes to
//   other indexes are ignored. The configuration registers reset to 0.
//   Request: a value is taken at a clock edge with start high and busy low.
//   busy stays high until the last byte of that value has been issued.
//   Results: each byte shows on character_o/last_o/invalid_o for one cycle with
//   strobe_o high; the receiver has no back-pressure and must take it.
// Operation (r = radix):
//   base check walks one symbol per cycle, up to r symbols; an invalid base
//   ends there with a single byte flagged invalid (character 0, last 1).
//   Each digit takes one full division in the shared serial divider; the
//   divide phase ends when the quotient reaches zero.
//   Emission: optional minus sign, a memory read, then one digit per
//   cycle, most significant first. A new request may be taken in the cycle
//   the final byte is shown.
// Reset: asynchronous, active low; sequencer returns to idle, strobe drops.
// The digit memory is not cleared; every entry read was written for that value.
module signed_radix_to_text_unit #(
  parameter int unsigned MAX_RADIX   = srtt_pkg::MaxRadixDef,
  parameter int unsigned VALUE_WIDTH = srtt_pkg::ValueWidthDef
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start,
  output logic                               busy,
  input  logic signed [VALUE_WIDTH-1:0]      value_i,
  input  logic                               cfg_we_i,
  input  logic [srtt_pkg::CfgIdxWidth-1:0]   cfg_index_i,
  input  logic [srtt_pkg::SymWordWidth-1:0]  cfg_data_i,
  output logic                               strobe_o,
  output logic [7:0]                         character_o,
  output logic                               last_o,
  output logic                               invalid_o
);
  import srtt_pkg::*;

  localparam int unsigned AddrWidth = $clog2(VALUE_WIDTH);
  localparam int unsigned CntWidth  = $clog2(VALUE_WIDTH + 1);

  // configuration registers
  logic [RadixWidth-1:0]   radix_q;
  logic [SymWordWidth-1:0] sym_low_q;
  logic [SymWordWidth-1:0] sym_high_q;

  // sequencer
  seq_state_e             state_q, state_d;
  logic [CntWidth-1:0]    cnt_q, cnt_d;
  logic [CntWidth-1:0]    cnt_m1;
  logic                   neg_q, neg_d;
  logic [VALUE_WIDTH-1:0] mag_q, mag_d;
  logic [VALUE_WIDTH-1:0] value_u;

  // shared units
  logic                   chk_start;
  chk_stat_t              chk_stat;
  logic                   div_start;
  logic [VALUE_WIDTH-1:0] dividend;
  logic [VALUE_WIDTH-1:0] quotient;
  div_stat_t              div_stat;

  // digit memory, least significant digit at address 0
  logic [DigitWidth-1:0]  digit_mem [VALUE_WIDTH];
  logic                   mem_we;
  logic                   mem_re;
  logic [AddrWidth-1:0]   rd_addr;
  logic [DigitWidth-1:0]  rd_data_q;

  // output register
  logic       strobe_q, strobe_d;
  logic [7:0] char_q, char_d;
  logic       last_q, last_d;
  logic       inv_q, inv_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q    <= '0;
      sym_low_q  <= '0;
      sym_high_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        RegRadix:   radix_q    <= cfg_data_i[RadixWidth-1:0];
        RegSymLow:  sym_low_q  <= cfg_data_i;
        RegSymHigh: sym_high_q <= cfg_data_i;
        default:    ;
      endcase
    end
  end

  srtt_base_check #(
    .MAX_RADIX (MAX_RADIX)
  ) u_check (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (chk_start),
    .radix_i    (radix_q),
    .sym_low_i  (sym_low_q),
    .sym_high_i (sym_high_q),
    .stat_o     (chk_stat)
  );

  srtt_divider #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (dividend),
    .divisor_i  (radix_q),
    .quotient_o (quotient),
    .stat_o     (div_stat)
  );

  assign value_u = value_i;
  assign cnt_m1  = cnt_q - CntWidth'(1);

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    neg_d     = neg_q;
    mag_d     = mag_q;
    chk_start = 1'b0;
    div_start = 1'b0;
    dividend  = mag_q;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    rd_addr   = cnt_m1[AddrWidth-1:0];
    strobe_d  = 1'b0;
    char_d    = char_q;
    last_d    = last_q;
    inv_d     = inv_q;

    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          // magnitude of the most negative value still fits unsigned
          neg_d     = value_u[VALUE_WIDTH-1];
          mag_d     = value_u[VALUE_WIDTH-1] ? (~value_u + VALUE_WIDTH'(1)) : value_u;
          chk_start = 1'b1;
          state_d   = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (chk_stat.done) begin
          if (chk_stat.ok) begin
            div_start = 1'b1;
            dividend  = mag_q;
            cnt_d     = '0;
            state_d   = ST_DIVIDE;
          end else begin
            strobe_d = 1'b1;
            char_d   = CharNul;
            last_d   = 1'b1;
            inv_d    = 1'b1;
            state_d  = ST_IDLE;
          end
        end
      end
      ST_DIVIDE: begin
        if (div_stat.done) begin
          mem_we = 1'b1;
          cnt_d  = cnt_q + CntWidth'(1);
          if (quotient != '0) begin
            div_start = 1'b1;
            dividend  = quotient;
          end else begin
            state_d = ST_READ;
            if (neg_q) begin
              strobe_d = 1'b1;
              char_d   = CharMinus;
              last_d   = 1'b0;
              inv_d    = 1'b0;
            end
          end
        end
      end
      ST_READ: begin
        // fetch the most significant digit
        mem_re  = 1'b1;
        cnt_d   = cnt_m1;
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        strobe_d = 1'b1;
        char_d   = symbol_at(sym_low_q, sym_high_q, rd_data_q);
        last_d   = (cnt_q == '0);
        inv_d    = 1'b0;
        if (cnt_q == '0) begin
          state_d = ST_IDLE;
        end else begin
          mem_re = 1'b1;
          cnt_d  = cnt_m1;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      cnt_q    <= '0;
      strobe_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      strobe_q <= strobe_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q  <= neg_d;
    mag_q  <= mag_d;
    char_q <= char_d;
    last_q <= last_d;
    inv_q  <= inv_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      digit_mem[cnt_q[AddrWidth-1:0]] <= div_stat.remainder;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_re) begin
      rd_data_q <= digit_mem[rd_addr];
    end
  end

  assign busy        = (state_q != ST_IDLE);
  assign strobe_o    = strobe_q;
  assign character_o = char_q;
  assign last_o      = last_q;
  assign invalid_o   = inv_q;

endmodule

// ===== design/srtt_base_check.sv =====
// Iterative base validity check: one symbol per cycle against all later symbols below the radix.
module srtt_base_check #(
  parameter int unsigned MAX_RADIX = srtt_pkg::MaxRadixDef
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic [srtt_pkg::RadixWidth-1:0]     radix_i,
  input  logic [srtt_pkg::SymWordWidth-1:0]   sym_low_i,
  input  logic [srtt_pkg::SymWordWidth-1:0]   sym_high_i,
  output srtt_pkg::chk_stat_t                 stat_o
);
  import srtt_pkg::*;

  logic                  run_q;
  logic [DigitWidth-1:0] idx_q;
  logic [7:0]            cur;
  logic                  dup;
  logic                  range_bad;
  logic                  sym_bad;
  logic                  at_end;
  logic [RadixWidth-1:0] radix_m1;

  always_comb begin
    cur = symbol_at(sym_low_i, sym_high_i, idx_q);
    dup = 1'b0;
    for (int j = 0; j < SymbolCount; j++) begin
      if ((RadixWidth'(j) > {1'b0, idx_q}) && (RadixWidth'(j) < radix_i) &&
          (symbol_at(sym_low_i, sym_high_i, DigitWidth'(j)) == cur)) begin
        dup = 1'b1;
      end
    end
    range_bad = (radix_i < MinRadix) || (radix_i > RadixWidth'(MAX_RADIX));
    sym_bad   = (cur == CharNul) || (cur == CharPlus) || (cur == CharMinus) || dup;
    radix_m1  = radix_i - RadixWidth'(1);
    at_end    = ({1'b0, idx_q} == radix_m1);
    stat_o.done = run_q & (range_bad | sym_bad | at_end);
    stat_o.ok   = ~(range_bad | sym_bad);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
      idx_q <= '0;
    end else if (start_i) begin
      run_q <= 1'b1;
      idx_q <= '0;
    end else if (run_q) begin
      if (stat_o.done) begin
        run_q <= 1'b0;
      end
      idx_q <= idx_q + DigitWidth'(1);
    end
  end

endmodule

// ===== design/srtt_divider.sv =====
// Restoring serial divider by the radix: one quotient bit per cycle.
module srtt_divider #(
  parameter int unsigned VALUE_WIDTH = srtt_pkg::ValueWidthDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic [VALUE_WIDTH-1:0]            dividend_i,
  input  logic [srtt_pkg::RadixWidth-1:0]   divisor_i,
  output logic [VALUE_WIDTH-1:0]            quotient_o,
  output srtt_pkg::div_stat_t               stat_o
);
  import srtt_pkg::*;

  localparam int unsigned CntWidth = $clog2(VALUE_WIDTH);

  logic                   run_q;
  logic                   done_q;
  logic [CntWidth-1:0]    cnt_q;
  logic [VALUE_WIDTH-1:0] quo_q;
  logic [DigitWidth-1:0]  rem_q;
  logic [RadixWidth-1:0]  trial;
  logic [RadixWidth-1:0]  diff;
  logic                   fits;

  // partial remainder stays below the divisor, so trial fits in five bits
  assign trial = {rem_q, quo_q[VALUE_WIDTH-1]};
  assign fits  = (trial >= divisor_i);
  assign diff  = trial - divisor_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= CntWidth'(VALUE_WIDTH - 1);
      end else if (run_q) begin
        cnt_q <= cnt_q - CntWidth'(1);
        if (cnt_q == '0) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
    end else if (run_q) begin
      quo_q <= {quo_q[VALUE_WIDTH-2:0], fits};
      rem_q <= fits ? diff[DigitWidth-1:0] : trial[DigitWidth-1:0];
    end
  end

  assign quotient_o       = quo_q;
  assign stat_o.done      = done_q;
  assign stat_o.remainder = rem_q;

endmodule
